[hw/rtl/tournament_branch_predictor_macros.svh]
// assertion helpers shared by the predictor rtl
`ifndef TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define TBP_ASSERT_NOW(label, rst_n, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TBP_ASSERT_NXT(label, rst_n, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tbp_pkg.sv]
`default_nettype none

package tbp_pkg;

    localparam int TBP_BTB_ENTRIES        = 256;
    localparam int TBP_HISTORY_BITS       = 8;
    localparam int TBP_LOCAL_HISTORY_BITS = 8;

    localparam int CTR_W     = 2;
    localparam int CHOOSER_W = 3;

    localparam logic [CTR_W-1:0]     CTR_MAX       = 2'd3;
    localparam logic [CTR_W-1:0]     CTR_TAKEN_MIN = 2'd2;
    localparam logic [CHOOSER_W-1:0] CHOOSER_MAX   = 3'd7;
    localparam logic [CHOOSER_W-1:0] CHOOSER_INIT  = 3'd4;
    localparam logic [CHOOSER_W-1:0] CHOOSER_GSEL  = 3'd4;
    localparam logic [31:0]          PC_STEP       = 32'd4;

    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_UPDATE  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LHIST = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    function automatic logic [CTR_W-1:0] ctr_bump(input logic [CTR_W-1:0] c, input logic up);
        logic [CTR_W-1:0] r;
        r = c;
        if (up) begin
            if (c < CTR_MAX) r = c + 2'd1;
        end else begin
            if (c != '0) r = c - 2'd1;
        end
        return r;
    endfunction

    function automatic logic [CHOOSER_W-1:0] chooser_bump(input logic [CHOOSER_W-1:0] c,
                                                          input logic up);
        logic [CHOOSER_W-1:0] r;
        r = c;
        if (up) begin
            if (c < CHOOSER_MAX) r = c + 3'd1;
        end else begin
            if (c != '0) r = c - 3'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tbp_ctr_mem.sv]
`default_nettype none

module tbp_ctr_mem
    import tbp_pkg::*;
#(
    parameter int AW = TBP_HISTORY_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [AW-1:0]     i_rd_addr,
    output logic      [CTR_W-1:0]  o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [CTR_W-1:0]  i_wr_data
);

    localparam int DEPTH = 1 << AW;

    logic [CTR_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tbp_entry_mem.sv]
`default_nettype none

module tbp_entry_mem
    import tbp_pkg::*;
#(
    parameter int DEPTH = TBP_BTB_ENTRIES,
    parameter int AW    = $clog2(TBP_BTB_ENTRIES),
    parameter int LW    = TBP_LOCAL_HISTORY_BITS,
    parameter int TW    = 32 - $clog2(TBP_BTB_ENTRIES)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rd_en,
    input  wire logic [AW-1:0]        i_rd_addr,
    output logic      [LW-1:0]        o_rd_lhist,
    output logic      [CHOOSER_W-1:0] o_rd_chooser,
    output logic                      o_rd_valid,
    output logic      [TW-1:0]        o_rd_tag,
    output logic      [31:0]          o_rd_target,
    input  wire logic                 i_wr_en,
    input  wire logic [AW-1:0]        i_wr_addr,
    input  wire logic [LW-1:0]        i_wr_lhist,
    input  wire logic [CHOOSER_W-1:0] i_wr_chooser,
    input  wire logic                 i_wr_valid,
    input  wire logic [TW-1:0]        i_wr_tag,
    input  wire logic [31:0]          i_wr_target
);

    // one row per entry: local history, chooser, target buffer
    logic [LW-1:0]        r_lhist   [DEPTH];
    logic [CHOOSER_W-1:0] r_chooser [DEPTH];
    logic                 r_valid   [DEPTH];
    logic [TW-1:0]        r_tag     [DEPTH];
    logic [31:0]          r_target  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_lhist[i_wr_addr]   <= i_wr_lhist;
            r_chooser[i_wr_addr] <= i_wr_chooser;
            r_valid[i_wr_addr]   <= i_wr_valid;
            r_tag[i_wr_addr]     <= i_wr_tag;
            r_target[i_wr_addr]  <= i_wr_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_lhist   <= r_lhist[i_rd_addr];
            o_rd_chooser <= r_chooser[i_rd_addr];
            o_rd_valid   <= r_valid[i_rd_addr];
            o_rd_tag     <= r_tag[i_rd_addr];
            o_rd_target  <= r_target[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tournament_branch_predictor.sv]
// tournament branch predictor: gshare and local-history sides, a per-entry
// chooser and a tagged target buffer
// input stream: tuser is the operation (predict or update), tdata carries
// pc, actual next pc and the taken flag; one word per branch or fetch
// output stream: one word per predict (next pc and taken), none per update
// timing: an accepted word passes S_LHIST and S_EXEC, and a predict result
// is then registered in the output register; S_EXEC holds a predict while
// that register still holds an unread result; a new word is accepted only
// once the last one has left S_EXEC, as the local counter read depends on the
// local history read: two dependent memory reads and a read-modify-write step
// after reset the tables are swept, one entry per cycle, over
// max(2^HISTORY_BITS, BTB_ENTRIES, 2^LOCAL_HISTORY_BITS) entries (256 by
// default); tready stays low during the sweep
// a result waits in the output register while the receiver stalls; the next
// word is still accepted, and only a second result stalls behind it
`default_nettype none
`include "tournament_branch_predictor_macros.svh"

module tournament_branch_predictor
    import tbp_pkg::*;
#(
    parameter int BTB_ENTRIES        = TBP_BTB_ENTRIES,
    parameter int HISTORY_BITS       = TBP_HISTORY_BITS,
    parameter int LOCAL_HISTORY_BITS = TBP_LOCAL_HISTORY_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,  // pc[31:0], actual_next_pc[63:32], taken[64], zero
    input  wire logic        i_s_tuser,  // func
    // master side
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [39:0] o_m_tdata   // pred_next_pc[31:0], pred_taken[32], zero
);

    localparam int IDX_W     = $clog2(BTB_ENTRIES);
    localparam int TAG_W     = 32 - IDX_W;
    localparam int G_DEPTH   = 1 << HISTORY_BITS;
    localparam int L_DEPTH   = 1 << LOCAL_HISTORY_BITS;
    localparam int GL_MAX    = (G_DEPTH > L_DEPTH) ? G_DEPTH : L_DEPTH;
    localparam int CLR_DEPTH = (GL_MAX > BTB_ENTRIES) ? GL_MAX : BTB_ENTRIES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // control state
    t_state r_state, n_state;
    logic [CLR_W-1:0] r_clr_cnt;
    logic [HISTORY_BITS-1:0] r_ghist;
    logic r_out_valid;

    // latched item
    logic r_func;
    logic [31:0] r_pc;
    logic [31:0] r_next_pc;
    logic r_taken;
    logic [HISTORY_BITS-1:0] r_gidx;
    logic [IDX_W-1:0] r_eidx;
    logic [LOCAL_HISTORY_BITS-1:0] r_lidx;

    // output word
    logic [31:0] r_out_npc;
    logic r_out_taken;

    logic s_accept;
    logic clr_last;
    logic clr_g_en, clr_l_en, clr_e_en;
    logic out_free;
    logic exec_upd;
    logic exec_pred_load;

    logic [HISTORY_BITS-1:0] in_gidx;
    logic [IDX_W-1:0] in_eidx;

    // memory read data
    logic [CTR_W-1:0] gctr_rd, lctr_rd;
    logic [LOCAL_HISTORY_BITS-1:0] e_lhist;
    logic [CHOOSER_W-1:0] e_chooser;
    logic e_valid;
    logic [TAG_W-1:0] e_tag;
    logic [31:0] e_target;

    // memory write ports
    logic gctr_we, lctr_we, e_we;
    logic [HISTORY_BITS-1:0] gctr_wa;
    logic [LOCAL_HISTORY_BITS-1:0] lctr_wa;
    logic [IDX_W-1:0] e_wa;
    logic [CTR_W-1:0] gctr_wd, lctr_wd;
    logic [LOCAL_HISTORY_BITS-1:0] e_wd_lhist;
    logic [CHOOSER_W-1:0] e_wd_chooser;
    logic e_wd_valid;
    logic [TAG_W-1:0] e_wd_tag;
    logic [31:0] e_wd_target;

    // prediction and training
    logic [TAG_W-1:0] pc_tag;
    logic gpred, lpred, pred, btb_hit;
    logic [31:0] pred_npc;
    logic [CTR_W-1:0] g_new, l_new;
    logic gok, lok;
    logic [CHOOSER_W-1:0] chooser_new;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    // gshare index from the current global history, entry index from pc
    assign in_gidx = i_s_tdata[HISTORY_BITS+1:2] ^ r_ghist;
    assign in_eidx = i_s_tdata[IDX_W+1:2] & IDX_W'(BTB_ENTRIES - 1);

    assign clr_last = (r_clr_cnt == CLR_W'(CLR_DEPTH - 1));
    assign clr_g_en = ({1'b0, r_clr_cnt} < (CLR_W+1)'(G_DEPTH));
    assign clr_l_en = ({1'b0, r_clr_cnt} < (CLR_W+1)'(L_DEPTH));
    assign clr_e_en = ({1'b0, r_clr_cnt} < (CLR_W+1)'(BTB_ENTRIES));

    assign out_free       = !r_out_valid || i_m_tready;
    assign exec_upd       = (r_state == S_EXEC) && (r_func == FUNC_UPDATE);
    assign exec_pred_load = (r_state == S_EXEC) && (r_func == FUNC_PREDICT) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_accept) n_state = S_LHIST;
            end
            S_LHIST: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                // a predict waits here while the output register is still full
                if (exec_upd || exec_pred_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // prediction from the counters read for this item
    assign pc_tag   = r_pc[31:IDX_W];
    assign gpred    = (gctr_rd >= CTR_TAKEN_MIN);
    assign lpred    = (lctr_rd >= CTR_TAKEN_MIN);
    assign pred     = (e_chooser >= CHOOSER_GSEL) ? gpred : lpred;
    assign btb_hit  = e_valid && (e_tag == pc_tag);
    assign pred_npc = (pred && btb_hit) ? e_target : (r_pc + PC_STEP);

    // training; the chooser is judged on the updated counters
    assign g_new = ctr_bump(gctr_rd, r_taken);
    assign l_new = ctr_bump(lctr_rd, r_taken);
    assign gok   = ((g_new >= CTR_TAKEN_MIN) == r_taken);
    assign lok   = ((l_new >= CTR_TAKEN_MIN) == r_taken);
    assign chooser_new = (gok != lok) ? chooser_bump(e_chooser, gok) : e_chooser;

    // write ports: the reset sweep, else the update write-back
    always_comb begin
        if (r_state == S_CLEAR) begin
            gctr_we      = clr_g_en;
            lctr_we      = clr_l_en;
            e_we         = clr_e_en;
            gctr_wa      = r_clr_cnt[HISTORY_BITS-1:0];
            lctr_wa      = r_clr_cnt[LOCAL_HISTORY_BITS-1:0];
            e_wa         = r_clr_cnt[IDX_W-1:0];
            gctr_wd      = '0;
            lctr_wd      = '0;
            e_wd_lhist   = '0;
            e_wd_chooser = CHOOSER_INIT;
            e_wd_valid   = 1'b0;
            e_wd_tag     = '0;
            e_wd_target  = '0;
        end else begin
            gctr_we      = exec_upd;
            lctr_we      = exec_upd;
            e_we         = exec_upd;
            gctr_wa      = r_gidx;
            lctr_wa      = r_lidx;
            e_wa         = r_eidx;
            gctr_wd      = g_new;
            lctr_wd      = l_new;
            e_wd_lhist   = LOCAL_HISTORY_BITS'({e_lhist, r_taken});
            e_wd_chooser = chooser_new;
            // only taken branches fill the target buffer
            e_wd_valid   = r_taken ? 1'b1 : e_valid;
            e_wd_tag     = r_taken ? pc_tag : e_tag;
            e_wd_target  = r_taken ? r_next_pc : e_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_ghist     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (exec_upd) begin
                r_ghist <= HISTORY_BITS'({r_ghist, r_taken});
            end
            if (exec_pred_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_func    <= i_s_tuser;
            r_pc      <= i_s_tdata[31:0];
            r_next_pc <= i_s_tdata[63:32];
            r_taken   <= i_s_tdata[64];
            r_gidx    <= in_gidx;
            r_eidx    <= in_eidx;
        end
        if (r_state == S_LHIST) begin
            r_lidx <= e_lhist;
        end
        if (exec_pred_load) begin
            r_out_npc   <= pred_npc;
            r_out_taken <= pred;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_taken, r_out_npc};

    tbp_ctr_mem #(
        .AW(HISTORY_BITS)
    ) u_gctr (
        .i_clk    (i_clk),
        .i_rd_en  (s_accept),
        .i_rd_addr(in_gidx),
        .o_rd_data(gctr_rd),
        .i_wr_en  (gctr_we),
        .i_wr_addr(gctr_wa),
        .i_wr_data(gctr_wd)
    );

    // local counters are read once the local history has come back
    tbp_ctr_mem #(
        .AW(LOCAL_HISTORY_BITS)
    ) u_lctr (
        .i_clk    (i_clk),
        .i_rd_en  (r_state == S_LHIST),
        .i_rd_addr(e_lhist),
        .o_rd_data(lctr_rd),
        .i_wr_en  (lctr_we),
        .i_wr_addr(lctr_wa),
        .i_wr_data(lctr_wd)
    );

    tbp_entry_mem #(
        .DEPTH(BTB_ENTRIES),
        .AW   (IDX_W),
        .LW   (LOCAL_HISTORY_BITS),
        .TW   (TAG_W)
    ) u_entry (
        .i_clk       (i_clk),
        .i_rd_en     (s_accept),
        .i_rd_addr   (in_eidx),
        .o_rd_lhist  (e_lhist),
        .o_rd_chooser(e_chooser),
        .o_rd_valid  (e_valid),
        .o_rd_tag    (e_tag),
        .o_rd_target (e_target),
        .i_wr_en     (e_we),
        .i_wr_addr   (e_wa),
        .i_wr_lhist  (e_wd_lhist),
        .i_wr_chooser(e_wd_chooser),
        .i_wr_valid  (e_wd_valid),
        .i_wr_tag    (e_wd_tag),
        .i_wr_target (e_wd_target)
    );

    `TBP_ASSERT_NXT(a_accept_reads, i_rst_n, s_accept, r_state == S_LHIST, "accept did not start lookup")
    `TBP_ASSERT_NXT(a_update_done, i_rst_n, exec_upd, r_state == S_IDLE, "update did not retire")
    `TBP_ASSERT_NXT(a_pred_out, i_rst_n, exec_pred_load, o_m_tvalid && (r_state == S_IDLE), "predict result not loaded")
    `TBP_ASSERT_NXT(a_ghist_hold, i_rst_n, !exec_upd, $stable(r_ghist), "global history moved without update")

endmodule

`default_nettype wire

[bench/tournament_branch_predictor_tb.sv]
`timescale 1ns / 1ps

module tournament_branch_predictor_tb;
    import tbp_pkg::*;

    localparam int GH_W    = TBP_HISTORY_BITS;
    localparam int LH_W    = TBP_LOCAL_HISTORY_BITS;
    localparam int ENTRIES = TBP_BTB_ENTRIES;
    localparam int ENTRY_W = $clog2(TBP_BTB_ENTRIES);
    localparam int TAG_W   = 32 - ENTRY_W;
    localparam int RANDOM_WORDS = 1700;
    localparam int QUIET_TAIL   = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOT_COUNT    = 12;

    // branch behavior classes for the hot branch pool
    typedef enum int {
        PAT_ALWAYS,
        PAT_NEVER,
        PAT_LOOP,
        PAT_ALTERNATE,
        PAT_BIASED
    } t_pattern;

    typedef struct {
        logic        func;
        logic [31:0] pc;
        logic [31:0] target;
        logic        taken;
        bit          drain_first;  // hold this word until all results are back
    } branch_word_t;

    typedef struct {
        logic [31:0] next_pc;
        logic        taken;
    } fetch_guess_t;

    typedef struct {
        logic [31:0] pc;
        logic [31:0] target;
        t_pattern    pattern;
        int          period;
        int          visits;
    } hot_branch_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic         s_valid = 1'b0;
    wire          s_ready;
    branch_word_t s_word  = '{default: '0};
    wire          m_valid;
    logic         m_ready = 1'b0;
    wire [39:0]   m_data;

    // predictor state mirrored in the bench
    logic [GH_W-1:0]      ghist;
    logic [1:0]           gctr       [2**GH_W];
    logic [LH_W-1:0]      lhist      [ENTRIES];
    logic [1:0]           lctr       [2**LH_W];
    logic [2:0]           chooser    [ENTRIES];
    logic                 btb_valid  [ENTRIES];
    logic [TAG_W-1:0]     btb_tag    [ENTRIES];
    logic [31:0]          btb_target [ENTRIES];

    branch_word_t branch_words[$];
    fetch_guess_t expected_fetch[$];
    hot_branch_t  hot_pool[HOT_COUNT];

    bit word_sent = 1'b0;
    int send_gap  = 0;
    int recv_gap  = 0;
    int mismatches = 0;
    int cycle_count = 0;

    tournament_branch_predictor dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  ({7'd0, s_word.taken, s_word.target, s_word.pc}),
        .i_s_tuser  (s_word.func),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [1:0] sat_count(input logic [1:0] c, input logic up);
        if (up) begin
            return (c == CTR_MAX) ? c : c + 2'd1;
        end
        return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    // advance the mirrored tables by one accepted word
    task automatic model_branch(input branch_word_t w);
        logic [GH_W-1:0]    gidx;
        logic [ENTRY_W-1:0] eidx;
        logic [LH_W-1:0]    lidx;
        logic [TAG_W-1:0]   tag;
        logic               g_says, l_says, gok, lok;
        fetch_guess_t       guess;
        gidx = GH_W'((w.pc >> 2) ^ 32'(ghist));
        eidx = ENTRY_W'(w.pc >> 2);
        lidx = lhist[eidx];
        tag  = TAG_W'(w.pc >> ENTRY_W);
        if (w.func == FUNC_PREDICT) begin
            g_says = gctr[gidx] >= CTR_TAKEN_MIN;
            l_says = lctr[lidx] >= CTR_TAKEN_MIN;
            guess.taken   = (chooser[eidx] >= CHOOSER_GSEL) ? g_says : l_says;
            guess.next_pc = w.pc + PC_STEP;
            // taken with a tag miss still falls through to pc + 4
            if (guess.taken && btb_valid[eidx] && btb_tag[eidx] == tag)
                guess.next_pc = btb_target[eidx];
            expected_fetch.push_back(guess);
        end else begin
            gctr[gidx]  = sat_count(gctr[gidx], w.taken);
            lctr[lidx]  = sat_count(lctr[lidx], w.taken);
            ghist       = GH_W'({ghist, w.taken});
            lhist[eidx] = LH_W'({lhist[eidx], w.taken});
            // chooser judged on the freshly trained counters
            gok = (gctr[gidx] >= CTR_TAKEN_MIN) == w.taken;
            lok = (lctr[lidx] >= CTR_TAKEN_MIN) == w.taken;
            if (gok && !lok && chooser[eidx] != CHOOSER_MAX)
                chooser[eidx] = chooser[eidx] + 3'd1;
            else if (lok && !gok && chooser[eidx] != 3'd0)
                chooser[eidx] = chooser[eidx] - 3'd1;
            if (w.taken) begin
                btb_valid[eidx]  = 1'b1;
                btb_tag[eidx]    = tag;
                btb_target[eidx] = w.target;
            end
        end
    endtask

    task automatic add_word(input logic func, input logic [31:0] pc,
                            input logic [31:0] target, input logic taken);
        branch_word_t w;
        w.func        = func;
        w.pc          = pc;
        w.target      = target;
        w.taken       = taken;
        w.drain_first = 1'b0;
        branch_words.push_back(w);
    endtask

    function automatic logic hot_outcome(inout hot_branch_t h);
        logic t;
        case (h.pattern)
            PAT_ALWAYS:    t = 1'b1;
            PAT_NEVER:     t = 1'b0;
            PAT_LOOP:      t = (h.visits % h.period) != h.period - 1;
            PAT_ALTERNATE: t = h.visits[0];
            default:       t = $urandom_range(0, 9) < 8;
        endcase
        h.visits++;
        return t;
    endfunction

    // driver: one decision per falling edge, one assignment per signal
    always @(negedge clk) begin
        branch_word_t nxt_word;
        logic         nxt_valid;
        logic         nxt_ready;
        bit           quiet;
        nxt_word  = s_word;
        nxt_valid = s_valid;
        nxt_ready = m_ready;
        quiet     = branch_words.size() < QUIET_TAIL;
        if (rst_n) begin
            if (!s_valid || word_sent) begin
                nxt_valid = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (branch_words.size() > 0 &&
                             !(branch_words[0].drain_first && expected_fetch.size() > 0)) begin
                    nxt_word  = branch_words.pop_front();
                    nxt_valid = 1'b1;
                    if (!quiet && $urandom_range(0, 6) == 0)
                        send_gap = $urandom_range(1, 4);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    recv_gap = $urandom_range(1, 4);
            end
        end
        s_word  <= nxt_word;
        s_valid <= nxt_valid;
        m_ready <= nxt_ready;
    end

    // monitor: model accepted words, check accepted results, watch the clock
    always @(posedge clk) begin
        fetch_guess_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else if (rst_n) begin
            if (m_valid && m_ready) begin
                if (expected_fetch.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: next pc %h taken %0d",
                                 m_data[31:0], m_data[32]);
                end else begin
                    want = expected_fetch.pop_front();
                    if (m_data[31:0] !== want.next_pc || m_data[32] !== want.taken) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: next pc %h (want %h) taken %0d (want %0d)",
                                     m_data[31:0], want.next_pc, m_data[32], want.taken);
                    end
                end
            end
            word_sent = s_valid && s_ready;
            if (word_sent)
                model_branch(s_word);
        end
    end

    initial begin
        int          produced;
        int          pick;
        int          roll;
        logic        t;
        logic [31:0] alias_pc;

        ghist = '0;
        for (int i = 0; i < 2**GH_W; i++) gctr[i] = '0;
        for (int i = 0; i < 2**LH_W; i++) lctr[i] = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            lhist[i]      = '0;
            chooser[i]    = CHOOSER_INIT;
            btb_valid[i]  = 1'b0;
            btb_tag[i]    = '0;
            btb_target[i] = '0;
        end

        // directed: address extremes, wraparound, btb fill, hit, tag miss
        add_word(FUNC_PREDICT, 32'h0000_0000, 32'h0, 1'b0);
        add_word(FUNC_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0);
        add_word(FUNC_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_word(FUNC_UPDATE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        add_word(FUNC_UPDATE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        add_word(FUNC_PREDICT, 32'hFFFF_FFFF, 32'h0, 1'b0);
        for (int i = 0; i < 5; i++) begin
            add_word(FUNC_UPDATE,  32'h0000_2040, 32'h0000_8000, 1'b1);
            add_word(FUNC_PREDICT, 32'h0000_2040, 32'h0, 1'b0);
        end
        // same entry, other tag: taken guess with a btb miss
        add_word(FUNC_PREDICT, 32'h0000_2440, 32'h0, 1'b0);
        // not-taken update leaves the target alone
        add_word(FUNC_UPDATE,  32'h0000_2040, 32'h1234_5678, 1'b0);
        add_word(FUNC_PREDICT, 32'h0000_2040, 32'h0, 1'b0);
        for (int i = 0; i < 3; i++) begin
            add_word(FUNC_UPDATE,  32'h8000_1004, 32'hFFFF_FFFF, i[0]);
            add_word(FUNC_PREDICT, 32'h8000_1004, 32'h0, 1'b0);
        end
        // the previous predict is still in flight when this one is due
        branch_words[branch_words.size() - 1].drain_first = 1'b1;

        for (int i = 0; i < HOT_COUNT; i++) begin
            hot_pool[i].pc      = $urandom();
            hot_pool[i].target  = $urandom();
            hot_pool[i].pattern = t_pattern'(i % 5);
            hot_pool[i].period  = $urandom_range(2, 9);
            hot_pool[i].visits  = 0;
        end

        // random: mostly predict/update pairs on hot branches, some noise
        produced = 0;
        while (produced < RANDOM_WORDS) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, HOT_COUNT - 1);
            if (roll < 75) begin
                t = hot_outcome(hot_pool[pick]);
                add_word(FUNC_PREDICT, hot_pool[pick].pc, $urandom(),
                         1'($urandom_range(0, 1)));
                add_word(FUNC_UPDATE, hot_pool[pick].pc, hot_pool[pick].target, t);
                produced += 2;
            end else if (roll < 85) begin
                // alias onto a hot entry with a different tag
                alias_pc = hot_pool[pick].pc ^ ({$urandom()} << (ENTRY_W + 2));
                if (alias_pc == hot_pool[pick].pc) alias_pc = alias_pc ^ 32'h8000_0000;
                add_word(FUNC_PREDICT, alias_pc, 32'h0, 1'b0);
                add_word(FUNC_UPDATE, alias_pc, $urandom(), 1'($urandom_range(0, 1)));
                produced += 2;
            end else begin
                add_word(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                         1'($urandom_range(0, 1)));
                produced++;
            end
            if (produced == 2 || produced == RANDOM_WORDS / 2)
                branch_words[branch_words.size() - 1].drain_first = 1'b1;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (branch_words.size() != 0 || s_valid) @(posedge clk);
        while (expected_fetch.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
